// ----- rtl/srrp_pkg.sv -----
// Shared types, widths and constants for the sampled read range planner.
package srrp_pkg;

	// Block size is 2^BLOCK_SHIFT bytes (legal range 12..30).
	localparam int BLOCK_SHIFT = 20;

	localparam int SIZE_W = 64;
	localparam int PCT_W  = 8;
	localparam int PAT_W  = 2;

	// size * pct (pct <= 99 fits 7 bits) plus rounding half, one carry bit spare.
	localparam int MUL_W  = SIZE_W + 7;
	localparam int PROD_W = MUL_W + 1;

	// floor(P / (100 << S)) = floor((P >> (S+2)) / 25)
	localparam int Z_W  = PROD_W - BLOCK_SHIFT - 2;
	localparam int ZL_W = Z_W / 2;
	localparam int ZH_W = Z_W - ZL_W;

	// reciprocal divide by 25: m = ceil(2^k / 25), k = N + 5
	localparam int QH_W = ZH_W - 4;
	localparam int KH   = ZH_W + 5;
	localparam int MH_W = KH - 4;
	localparam logic [63:0] MH_WIDE = ((64'd1 << KH) + 64'd24) / 64'd25;
	localparam int W_W  = ZL_W + 5;
	localparam int KL   = W_W + 5;
	localparam int ML_W = KL - 4;
	localparam logic [63:0] ML_WIDE = ((64'd1 << KL) + 64'd24) / 64'd25;

	localparam int T_W  = QH_W + ZL_W;        // block target width
	localparam int NB_W = SIZE_W - BLOCK_SHIFT; // whole-block count width
	localparam int WH_W = NB_W + 1;           // ceil block count width

	localparam logic [PROD_W-1:0] HALF_DENOM = PROD_W'(50) << BLOCK_SHIFT;

	localparam logic [PAT_W-1:0] PAT_EDGES  = 2'd0;
	localparam logic [PAT_W-1:0] PAT_CENTER = 2'd1;
	localparam logic [PAT_W-1:0] PAT_RANDOM = 2'd2;

	localparam logic EFF_EDGES  = 1'b0;
	localparam logic EFF_CENTER = 1'b1;

	localparam logic [PCT_W-1:0] FULL_PCT  = 8'd100;
	localparam logic [63:0] THRESH_RESET   = 64'd2097152;

	typedef struct packed {
		logic [SIZE_W-1:0] file_size;
		logic [PCT_W-1:0]  sample_percent;
		logic [PAT_W-1:0]  pattern_code;
	} cmd_t;

	typedef struct packed {
		logic              full_read;
		logic [SIZE_W-1:0] first_offset;
		logic [SIZE_W-1:0] first_length;
		logic [SIZE_W-1:0] second_offset;
		logic [SIZE_W-1:0] second_length;
		logic [PCT_W-1:0]  effective_percent;
		logic              effective_pattern;
	} res_t;

	// per-word control carried down the pipe
	typedef struct packed {
		logic             valid;
		logic             full;    // full read decided up front
		logic             center;
		logic [PCT_W-1:0] req;
	} ctl_t;

endpackage

// ----- rtl/srrp_front.sv -----
// Input register and percent-scaled size product.
module srrp_front import srrp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cmd_t              cmd,
	input  logic [SIZE_W-1:0] threshold,
	output ctl_t              ctl_s2,
	output logic [SIZE_W-1:0] size_s2,
	output logic [Z_W-1:0]    z_s2
);

	ctl_t              ctl_s1;
	logic [SIZE_W-1:0] size_s1;
	logic [6:0]        pct_s1;
	ctl_t              ctl_in;
	logic [MUL_W-1:0]  mul;
	logic [PROD_W-1:0] prod;

	always_comb begin
		ctl_in.valid  = start;
		ctl_in.full   = (cmd.file_size <= threshold) || (cmd.sample_percent >= FULL_PCT);
		ctl_in.center = (cmd.pattern_code == PAT_CENTER);
		ctl_in.req    = cmd.sample_percent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	// zero percent counts as one
	always_ff @(posedge clk) begin
		size_s1 <= cmd.file_size;
		pct_s1  <= (cmd.sample_percent == '0) ? 7'd1 : cmd.sample_percent[6:0];
	end

	assign mul  = size_s1 * pct_s1;
	assign prod = {1'b0, mul} + HALF_DENOM;

	always_ff @(posedge clk) begin
		size_s2 <= size_s1;
		z_s2    <= prod[PROD_W-1:BLOCK_SHIFT+2];
	end

endmodule

// ----- rtl/srrp_div25.sv -----
// Two-stage divide by 25 using reciprocal multiplies on half-width chunks.
module srrp_div25 import srrp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl_s2,
	input  logic [SIZE_W-1:0] size_s2,
	input  logic [Z_W-1:0]    z_s2,
	output ctl_t              ctl_s4,
	output logic [SIZE_W-1:0] size_s4,
	output logic [T_W-1:0]    target_s4
);

	localparam logic [MH_W-1:0] MH = MH_WIDE[MH_W-1:0];
	localparam logic [ML_W-1:0] ML = ML_WIDE[ML_W-1:0];

	logic [ZH_W-1:0]      zh;
	logic [ZH_W+MH_W-1:0] mh_prod;
	logic [QH_W-1:0]      qh;
	logic [ZH_W-1:0]      qh_x25;
	logic [ZH_W-1:0]      rh_wide;

	ctl_t              ctl_s3;
	logic [SIZE_W-1:0] size_s3;
	logic [QH_W-1:0]   qh_s3;
	logic [4:0]        rh_s3;
	logic [ZL_W-1:0]   zl_s3;

	logic [W_W-1:0]       w;
	logic [W_W+ML_W-1:0]  ml_prod;
	logic [ZL_W-1:0]      ql;

	// high chunk: quotient and remainder (x25 as shift-add)
	assign zh      = z_s2[Z_W-1:ZL_W];
	assign mh_prod = zh * MH;
	assign qh      = mh_prod[KH +: QH_W];
	assign qh_x25  = (ZH_W'(qh) << 4) + (ZH_W'(qh) << 3) + ZH_W'(qh);
	assign rh_wide = zh - qh_x25;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		size_s3 <= size_s2;
		qh_s3   <= qh;
		rh_s3   <= rh_wide[4:0];
		zl_s3   <= z_s2[ZL_W-1:0];
	end

	// low chunk with the carried remainder, below 25 << ZL_W
	assign w       = {rh_s3, zl_s3};
	assign ml_prod = w * ML;
	assign ql      = ml_prod[KL +: ZL_W];

	always_ff @(posedge clk) begin
		size_s4   <= size_s3;
		target_s4 <= {qh_s3, ql};
	end

endmodule

// ----- rtl/srrp_plan.sv -----
// Range layout and result register.
module srrp_plan import srrp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl_s4,
	input  logic [SIZE_W-1:0] size_s4,
	input  logic [T_W-1:0]    target_s4,
	output logic              done,
	output res_t              result
);

	logic [T_W-1:0]   tgt;
	logic [NB_W-1:0]  nblocks;
	logic [WH_W-1:0]  whole;
	logic             full;
	logic [NB_W-1:0]  spare;
	logic [NB_W:0]    before_sum;
	logic [T_W:0]     head_sum;
	logic [NB_W-1:0]  head;
	logic [NB_W-1:0]  tail;
	logic [SIZE_W-1:0] tail_len;
	res_t             res_d;

	assign tgt        = (target_s4 == '0) ? T_W'(1) : target_s4;
	assign nblocks    = size_s4[SIZE_W-1:BLOCK_SHIFT];
	assign whole      = {1'b0, nblocks} + WH_W'(|size_s4[BLOCK_SHIFT-1:0]);
	assign full       = ctl_s4.full || (tgt >= T_W'(whole));

	// center: odd spare block goes before the run
	assign spare      = nblocks - tgt[NB_W-1:0];
	assign before_sum = {1'b0, spare} + (NB_W+1)'(1);

	// edges: head takes the odd block
	assign head_sum   = {1'b0, tgt} + (T_W+1)'(1);
	assign head       = head_sum[NB_W:1];
	assign tail       = tgt[NB_W:1];
	assign tail_len   = {tail, {BLOCK_SHIFT{1'b0}}};

	always_comb begin
		res_d = '0;
		if (full) begin
			res_d.full_read         = 1'b1;
			res_d.effective_percent = FULL_PCT;
			res_d.effective_pattern = EFF_EDGES;
		end else if (ctl_s4.center) begin
			res_d.first_offset      = {before_sum[NB_W:1], {BLOCK_SHIFT{1'b0}}};
			res_d.first_length      = {tgt[NB_W-1:0], {BLOCK_SHIFT{1'b0}}};
			res_d.effective_percent = ctl_s4.req;
			res_d.effective_pattern = EFF_CENTER;
		end else begin
			res_d.first_length      = {head, {BLOCK_SHIFT{1'b0}}};
			if (tail != '0) begin
				res_d.second_offset = size_s4 - tail_len;
				res_d.second_length = tail_len;
			end
			res_d.effective_percent = ctl_s4.req;
			res_d.effective_pattern = EFF_EDGES;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		result <= res_d;
	end

endmodule

// ----- rtl/sampled_read_range_planner.sv -----
// A word passes the s1, s2, s3 and s4 registers and then the result register before its plan shows with done high.
// Throughput: one word per cycle; busy is never raised, so start may be high every cycle.
// Pipe: input reg, size*percent product, two reciprocal /25 steps, range layout + result reg.
// The receiver cannot stall: each result shows for one cycle only, flagged by done.
// Reset (arst_n low, async): pipe valids and done clear, threshold returns to 2 MiB.
// The user must write the threshold only with no word in flight; the block itself does not enforce this.
module sampled_read_range_planner import srrp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// command side
	input  logic              start,
	output logic              busy,
	input  cmd_t              cmd,
	// result side
	output logic              done,
	output res_t              result,
	// full-read threshold register
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata
);

	logic [SIZE_W-1:0] threshold_q;

	ctl_t              ctl_s2;
	logic [SIZE_W-1:0] size_s2;
	logic [Z_W-1:0]    z_s2;
	ctl_t              ctl_s4;
	logic [SIZE_W-1:0] size_s4;
	logic [T_W-1:0]    target_s4;

	// fully pipelined: every stage advances each cycle
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESH_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	// s1: capture word, early full-read decision; s2: size * pct + half block-unit
	srrp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.threshold (threshold_q),
		.ctl_s2    (ctl_s2),
		.size_s2   (size_s2),
		.z_s2      (z_s2)
	);

	// s3/s4: rounded block target = z / 25
	srrp_div25 u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s2    (ctl_s2),
		.size_s2   (size_s2),
		.z_s2      (z_s2),
		.ctl_s4    (ctl_s4),
		.size_s4   (size_s4),
		.target_s4 (target_s4)
	);

	// compare with whole-block count, lay out edges or center ranges
	srrp_plan u_plan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s4    (ctl_s4),
		.size_s4   (size_s4),
		.target_s4 (target_s4),
		.done      (done),
		.result    (result)
	);

endmodule

// ----- rtl/srrp_checker.sv -----
// Port-level checks for the planner, bound to the top level.
module srrp_checker import srrp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input res_t result
);

	localparam logic [SIZE_W-1:0] BLK_MASK = (SIZE_W'(1) << BLOCK_SHIFT) - SIZE_W'(1);

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##5 done)
		else $error("accepted word gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 5))
		else $error("result without a word");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.full_read) |-> (result.first_offset == '0 &&
		result.first_length == '0 && result.second_offset == '0 &&
		result.second_length == '0 && result.effective_percent == FULL_PCT &&
		result.effective_pattern == EFF_EDGES))
		else $error("full read with ranges");

	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.full_read) |-> (result.first_length != '0 &&
		(result.first_length & BLK_MASK) == '0 &&
		(result.first_offset & BLK_MASK) == '0))
		else $error("partial read range not block aligned");

endmodule

bind sampled_read_range_planner srrp_checker u_srrp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ----- bench/sampled_read_range_planner_tb.sv -----
// Self-checking bench for the sampled read range planner: directed table, then random phases.
`timescale 1ns / 100ps

module sampled_read_range_planner_tb import srrp_pkg::*;;

	// clock, run limits
	localparam int CLK_HALF    = 6;
	localparam int RESET_CYC   = 10;
	localparam int TAIL_CYC    = 12;      // pipe is 5 deep, a little slack
	localparam int CYCLE_LIMIT = 200000;

	localparam logic [63:0]      BLK_BYTES  = 64'd1 << BLOCK_SHIFT;
	localparam logic [63:0]      MIB        = 64'd1 << 20;
	localparam logic [63:0]      SIZE_MAX   = '1;
	// code 3 is not assigned; the block must treat it as edges
	localparam logic [PAT_W-1:0] PAT_UNUSED = 2'd3;

	localparam int NUM_PHASES  = 7;
	localparam int PHASE_WORDS = 127;
	localparam int LAST_WORDS  = 40;      // all-ones threshold: every plan is a full read

	// DUT signals
	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	cmd_t              cmd;
	logic              done;
	res_t              result;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;

	// one row of the directed table: a threshold write, or a word with an
	// optional hand-written plan (otherwise the predictor supplies it)
	typedef struct {
		bit          is_thr;
		logic [63:0] thr_val;
		cmd_t        word;
		bit          typed;
		res_t        plan;
	} dir_row_t;

	dir_row_t    dir_rows[$];
	res_t        plans_due[$];      // expected plans, oldest first
	res_t        plan_want;
	logic [63:0] thr_model;         // bench copy of full_read_threshold
	int          mismatches   = 0;
	int          words_sent   = 0;
	int          plans_seen   = 0;
	int          full_seen    = 0;
	int          center_seen  = 0;
	int          tail_seen    = 0;
	int          thr_settings = 1;  // reset value counts as the first setting
	int          cycle_count  = 0;

	sampled_read_range_planner i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Full-read plan: all ranges zero, percent reads 100, pattern reads edges.
	function automatic res_t full_plan();
		res_t p;
		p                   = '0;
		p.full_read         = 1'b1;
		p.effective_percent = FULL_PCT;
		p.effective_pattern = EFF_EDGES;
		return p;
	endfunction

	// Predictor: the range plan for one word under threshold thr.
	function automatic res_t plan_ranges(cmd_t w, logic [63:0] thr);
		logic [63:0] pct;
		logic [63:0] denom;
		logic [63:0] quot;
		logic [63:0] rest;
		logic [63:0] target;
		logic [64:0] whole;     // ceil(size / block), one bit wider so it cannot wrap
		logic [63:0] nblk;
		logic [63:0] spare;
		logic [63:0] head;
		logic [63:0] tail;
		res_t        p;

		p = full_plan();
		if (w.file_size <= thr || w.sample_percent >= FULL_PCT)
			return p;

		// a zero request sizes the plan as one percent
		pct   = (w.sample_percent == '0) ? 64'd1 : 64'(w.sample_percent);
		// round-half-up of size*pct / (100 blocks), split so nothing overflows
		denom  = 64'd100 * BLK_BYTES;
		quot   = w.file_size / denom;
		rest   = w.file_size % denom;
		target = quot * pct + (rest * pct + denom / 64'd2) / denom;
		if (target == '0)
			target = 64'd1;

		whole = {1'b0, w.file_size >> BLOCK_SHIFT}
			+ 65'((w.file_size & (BLK_BYTES - 64'd1)) != '0);
		// a plan that takes every block is just a full read
		if ({1'b0, target} >= whole)
			return p;

		p.full_read         = 1'b0;
		p.effective_percent = w.sample_percent;
		if (w.pattern_code == PAT_CENTER) begin
			// one run in the middle of the whole blocks, odd spare block goes before
			nblk                = w.file_size >> BLOCK_SHIFT;
			spare               = nblk - target;
			p.first_offset      = ((spare + 64'd1) / 64'd2) << BLOCK_SHIFT;
			p.first_length      = target << BLOCK_SHIFT;
			p.effective_pattern = EFF_CENTER;
		end else begin
			// edges (also random and the unused code): head takes the odd block
			head           = (target + 64'd1) / 64'd2;
			tail           = target / 64'd2;
			p.first_length = head << BLOCK_SHIFT;
			if (tail != '0) begin
				p.second_length = tail << BLOCK_SHIFT;
				p.second_offset = w.file_size - p.second_length;
			end
		end
		return p;
	endfunction

	// Random file size, mixed so that every region of the plan gets hit.
	function automatic logic [63:0] pick_size(logic [63:0] thr);
		logic [63:0] sz;
		case ($urandom_range(0, 6))
			0: sz = {$urandom, $urandom};
			1: sz = thr + 64'($urandom_range(0, 3)) - 64'd1;     // around the threshold
			2: sz = (64'($urandom_range(1, 400)) << 20) + 64'($urandom_range(0, 1048575));
			3: sz = {32'($urandom_range(0, 255)), $urandom} << $urandom_range(0, 24);
			4: sz = 64'($urandom);
			5: sz = 64'($urandom_range(1, 5000)) << BLOCK_SHIFT;  // exact block multiples
			default: sz = 64'($urandom_range(1, 8 << 20));        // a few blocks only
		endcase
		return sz;
	endfunction

	// directed table builders
	task automatic row_word(logic [63:0] sz, logic [PCT_W-1:0] pc, logic [PAT_W-1:0] pat);
		dir_row_t r;
		r        = '{default: '0};
		r.word   = '{file_size: sz, sample_percent: pc, pattern_code: pat};
		dir_rows.push_back(r);
	endtask

	task automatic row_plan(logic [63:0] sz, logic [PCT_W-1:0] pc, logic [PAT_W-1:0] pat,
			res_t p);
		dir_row_t r;
		r       = '{default: '0};
		r.word  = '{file_size: sz, sample_percent: pc, pattern_code: pat};
		r.typed = 1'b1;
		r.plan  = p;
		dir_rows.push_back(r);
	endtask

	task automatic row_thr(logic [63:0] v);
		dir_row_t r;
		r         = '{default: '0};
		r.is_thr  = 1'b1;
		r.thr_val = v;
		dir_rows.push_back(r);
	endtask

	// Offer one word and hold it until taken; queue its expected plan at that edge.
	task automatic send_word(cmd_t w, bit typed, res_t typed_plan);
		start <= 1'b1;
		cmd   <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		plans_due.push_back(typed ? typed_plan : plan_ranges(w, thr_model));
		words_sent++;
	endtask

	task automatic idle_for(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Stop sending and wait for every outstanding plan.
	task automatic drain_plans();
		start <= 1'b0;
		while (plans_due.size() != 0)
			@(posedge clk);
	endtask

	// Threshold writes only with the pipe empty.
	task automatic write_threshold(logic [63:0] v);
		drain_plans();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		thr_model  = v;
		thr_settings++;
	endtask

	// Result side: a plan shows for one cycle with done high and cannot be held off,
	// so it is taken at the edge that ends that cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (plans_due.size() == 0) begin
				$error("plan arrived with no word outstanding");
				mismatches++;
			end else begin
				plan_want = plans_due.pop_front();
				plans_seen++;
				if (result.full_read !== plan_want.full_read) begin
					$error("full_read: expected %0d, got %0d",
						plan_want.full_read, result.full_read);
					mismatches++;
				end
				if (result.first_offset !== plan_want.first_offset) begin
					$error("first_offset: expected %0d, got %0d",
						plan_want.first_offset, result.first_offset);
					mismatches++;
				end
				if (result.first_length !== plan_want.first_length) begin
					$error("first_length: expected %0d, got %0d",
						plan_want.first_length, result.first_length);
					mismatches++;
				end
				if (result.second_offset !== plan_want.second_offset) begin
					$error("second_offset: expected %0d, got %0d",
						plan_want.second_offset, result.second_offset);
					mismatches++;
				end
				if (result.second_length !== plan_want.second_length) begin
					$error("second_length: expected %0d, got %0d",
						plan_want.second_length, result.second_length);
					mismatches++;
				end
				if (result.effective_percent !== plan_want.effective_percent) begin
					$error("effective_percent: expected %0d, got %0d",
						plan_want.effective_percent, result.effective_percent);
					mismatches++;
				end
				if (result.effective_pattern !== plan_want.effective_pattern) begin
					$error("effective_pattern: expected %0d, got %0d",
						plan_want.effective_pattern, result.effective_pattern);
					mismatches++;
				end
				if (plan_want.full_read)
					full_seen++;
				else if (plan_want.effective_pattern == EFF_CENTER)
					center_seen++;
				else if (plan_want.second_length != '0)
					tail_seen++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int   n_words;
		int   burst;
		int   sent;
		cmd_t w;
		res_t p;

		// every input known from time zero; reset held for a while, released once
		start     = 1'b0;
		cmd       = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		arst_n    = 1'b0;
		thr_model = THRESH_RESET;
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed table, starting on the reset threshold (2 MiB) ----
		// small file: zero size and exactly at the threshold
		row_plan(64'd0, 8'd50, PAT_EDGES, full_plan());
		row_plan(THRESH_RESET, 8'd50, PAT_CENTER, full_plan());
		row_word(THRESH_RESET + 64'd1, 8'd50, PAT_EDGES);
		// 100 percent and above
		row_plan(100 * MIB, 8'd100, PAT_EDGES, full_plan());
		row_plan(100 * MIB, 8'd255, PAT_CENTER, full_plan());
		// 100 MiB at 10 percent: 10 blocks, split 5 + 5 for edges
		p                   = '0;
		p.first_length      = 5 * MIB;
		p.second_offset     = 95 * MIB;
		p.second_length     = 5 * MIB;
		p.effective_percent = 8'd10;
		p.effective_pattern = EFF_EDGES;
		row_plan(100 * MIB, 8'd10, PAT_EDGES, p);
		// same for center: 90 spare blocks, 45 before the run
		p                   = '0;
		p.first_offset      = 45 * MIB;
		p.first_length      = 10 * MIB;
		p.effective_percent = 8'd10;
		p.effective_pattern = EFF_CENTER;
		row_plan(100 * MIB, 8'd10, PAT_CENTER, p);
		// single edges block: no tail range
		p                   = '0;
		p.first_length      = MIB;
		p.effective_percent = 8'd1;
		p.effective_pattern = EFF_EDGES;
		row_plan(100 * MIB, 8'd1, PAT_EDGES, p);
		// zero percent sizes as one percent but reports 0
		p.effective_percent = 8'd0;
		row_plan(100 * MIB, 8'd0, PAT_EDGES, p);
		// random and the unused code fall back to edges
		row_word(100 * MIB, 8'd37, PAT_RANDOM);
		row_word(100 * MIB + 64'd12345, 8'd37, PAT_UNUSED);
		// size extremes, where the block count rounding is widest
		row_word(SIZE_MAX, 8'd99, PAT_EDGES);
		row_word(SIZE_MAX, 8'd99, PAT_CENTER);
		row_word(SIZE_MAX, 8'd0, PAT_UNUSED);
		row_word(64'h8000_0000_0000_0000, 8'd1, PAT_CENTER);
		row_word(3 * MIB + 64'd1, 8'd99, PAT_CENTER);
		row_word(250 * MIB, 8'd1, PAT_CENTER);     // 2.5 blocks rounds up
		// threshold at zero: tiny files, some whose plan would take every block
		row_thr(64'd0);
		row_plan(64'd1, 8'd50, PAT_EDGES, full_plan());
		row_plan(MIB, 8'd99, PAT_CENTER, full_plan());
		row_word(MIB + 64'd1, 8'd99, PAT_EDGES);
		row_plan(64'd0, 8'd0, PAT_EDGES, full_plan());
		// threshold at all ones: nothing escapes a full read
		row_thr(SIZE_MAX);
		row_plan(SIZE_MAX, 8'd1, PAT_CENTER, full_plan());

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_thr) begin
				write_threshold(dir_rows[i].thr_val);
			end else begin
				send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].plan);
				if ($urandom_range(0, 2) == 0)
					idle_for($urandom_range(1, 3));
			end
		end

		// ---- random phases, one threshold setting each ----
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: write_threshold(BLK_BYTES);
				1: write_threshold(64'($urandom));
				2: write_threshold({$urandom, $urandom});
				3: write_threshold(64'd0);
				4: write_threshold(THRESH_RESET);
				5: write_threshold({32'($urandom_range(0, 15)), $urandom});
				default: write_threshold(SIZE_MAX);
			endcase
			n_words = (ph == NUM_PHASES - 1) ? LAST_WORDS : PHASE_WORDS;
			sent    = 0;
			while (sent < n_words) begin
				// burst of back-to-back words
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst && sent < n_words; b++) begin
					w.file_size      = pick_size(thr_model);
					w.sample_percent = PCT_W'(($urandom_range(0, 9) == 0) ?
						$urandom_range(100, 255) : $urandom_range(0, 99));
					w.pattern_code   = PAT_W'($urandom_range(0, 3));
					send_word(w, 1'b0, '0);
					sent++;
				end
				// gap: often none, sometimes idle, now and then a full drain
				if ($urandom_range(0, 29) == 0)
					drain_plans();
				else if ($urandom_range(0, 3) != 0)
					idle_for($urandom_range(1, 6));
			end
		end

		// wind down: everything in, then an idle tail to catch a stray done
		drain_plans();
		repeat (TAIL_CYC) @(posedge clk);

		$display("Sent %0d words over %0d threshold settings; checked %0d plans.",
			words_sent, thr_settings, plans_seen);
		$display("Plan mix: %0d full reads, %0d center runs, %0d edges with a tail range.",
			full_seen, center_seen, tail_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
